// ===== design/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers for the keyed cache; empty when SYNTH is set.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define FEKC_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("fekc assertion failed");
`define FEKC_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("fekc assertion failed");
`else
`define FEKC_ASSERT_IMP(lbl, ante, cons)
`define FEKC_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

// ===== design/fekc_pkg.sv =====
// ----------------------------------------------------------------------------
// fekc_pkg
// Shared types and constants of the FIFO-evicting keyed cache.
// ----------------------------------------------------------------------------
package fekc_pkg;

  localparam int KEY_W   = 32;
  localparam int SER_W   = 32;
  localparam int VER_W   = 32;
  localparam int PAY_W   = 64;
  localparam int STAMP_W = 48;
  localparam int MODE_W  = 3;
  localparam int TPORT_W = 2;
  localparam int LIM_W   = 5;

  localparam logic [SER_W-1:0] SER_MAX = '1;

  typedef enum logic [MODE_W-1:0] {
    MODE_INSERT    = 3'd0,
    MODE_LOOKUP    = 3'd1,
    MODE_REMOVE    = 3'd2,
    MODE_EXPIRY    = 3'd3,
    MODE_CLEAR     = 3'd4,
    MODE_SET_LIMIT = 3'd5
  } mode_t;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_SCAN,
    ST_DECIDE,
    ST_INSERT,
    ST_CLEAR,
    ST_FIN
  } state_t;

  typedef struct packed {
    logic               valid;
    logic [KEY_W-1:0]   key;
    logic [SER_W-1:0]   serial;
    logic [VER_W-1:0]   version;
    logic [PAY_W-1:0]   payload;
    logic [STAMP_W-1:0] stamp;
  } slot_t;

  localparam int SLOT_W = $bits(slot_t);

endpackage

// ===== design/fekc_ram.sv =====
// ----------------------------------------------------------------------------
// fekc_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module fekc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== design/fifo_evicting_keyed_cache.sv =====
// ----------------------------------------------------------------------------
// fifo_evicting_keyed_cache
// Per-type keyed table with oldest-first replacement, scanned by one compare
// unit over a single slot RAM.
// ----------------------------------------------------------------------------
// The bucket scan reads one RAM slot per cycle; an insert of a new key adds an
// insert step, and a type clear adds a clearing pass over the bucket. One
// transaction in flight at a time. An out-of-range type skips the scan.
// Reset: clearing pass over all NUM_TYPES * TABLE_DEPTH slots of the slot RAM,
// in_ready low meanwhile.
module fifo_evicting_keyed_cache #(
  parameter int TABLE_DEPTH = 16,
  parameter int NUM_TYPES   = 4
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [fekc_pkg::MODE_W-1:0]   in_mode,
  input  logic [fekc_pkg::TPORT_W-1:0]  in_cache_type,
  input  logic [fekc_pkg::KEY_W-1:0]    in_entry_id,
  input  logic [fekc_pkg::PAY_W-1:0]    in_payload,
  input  logic [fekc_pkg::VER_W-1:0]    in_version,
  input  logic [fekc_pkg::STAMP_W-1:0]  in_timestamp,
  input  logic [fekc_pkg::LIM_W-1:0]    in_limit_value,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          out_hit,
  output logic [fekc_pkg::PAY_W-1:0]    out_stored_payload,
  output logic [fekc_pkg::VER_W-1:0]    out_stored_version,
  output logic [fekc_pkg::STAMP_W-1:0]  out_stored_timestamp,
  output logic                          out_expired,
  output logic [fekc_pkg::LIM_W-1:0]    out_entry_count,
  output logic                          out_evicted,
  output logic [fekc_pkg::KEY_W-1:0]    out_evicted_id
);

  localparam int SLOTS   = TABLE_DEPTH * NUM_TYPES;
  localparam int SLOT_AW = SLOTS > 1 ? $clog2(SLOTS) : 1;
  localparam int IDX_W   = TABLE_DEPTH > 1 ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W   = $clog2(TABLE_DEPTH + 1);
  localparam int TYPE_W  = NUM_TYPES > 1 ? $clog2(NUM_TYPES) : 1;
  localparam int SC_W    = $clog2(SLOTS + 1);
  localparam int CMP_W   = CNT_W > fekc_pkg::LIM_W ? CNT_W : fekc_pkg::LIM_W;

  localparam logic [SC_W-1:0]  LAST_SLOT = SC_W'(SLOTS - 1);
  localparam logic [SC_W-1:0]  LAST_IDX  = SC_W'(TABLE_DEPTH - 1);
  localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(TABLE_DEPTH);
  localparam logic [CMP_W-1:0] DEPTH_CMP = CMP_W'(TABLE_DEPTH);

  fekc_pkg::state_t state_r, state_nxt;

  fekc_pkg::mode_t                 mode_r;
  logic [TYPE_W-1:0]               type_r;
  logic                            type_ok_r;
  logic [fekc_pkg::KEY_W-1:0]      key_r;
  logic [fekc_pkg::PAY_W-1:0]      pay_r;
  logic [fekc_pkg::VER_W-1:0]      ver_r;
  logic [fekc_pkg::STAMP_W-1:0]    stamp_r;
  logic [fekc_pkg::LIM_W-1:0]      lim_r;
  logic [SLOT_AW-1:0]              base_r;

  logic [CNT_W-1:0]                rd_cnt_r;
  logic                            pend_r;
  logic [IDX_W-1:0]                pend_idx_r;
  logic [SC_W-1:0]                 sweep_r;

  logic                            fnd_r;
  logic [IDX_W-1:0]                fnd_idx_r;
  fekc_pkg::slot_t                 fnd_word_r;
  logic                            old_r;
  logic [IDX_W-1:0]                old_idx_r;
  logic [fekc_pkg::SER_W-1:0]      old_ser_r;
  logic [fekc_pkg::KEY_W-1:0]      old_key_r;
  logic                            free_r;
  logic [IDX_W-1:0]                free_idx_r;
  logic                            evict_r;

  logic [CNT_W-1:0]                type_count_r  [NUM_TYPES];
  logic [fekc_pkg::LIM_W-1:0]      type_limit_r  [NUM_TYPES];
  logic [fekc_pkg::SER_W-1:0]      next_serial_r [NUM_TYPES];

  logic                            out_valid_r;
  logic                            out_hit_r;
  logic [fekc_pkg::PAY_W-1:0]      out_pay_r;
  logic [fekc_pkg::VER_W-1:0]      out_ver_r;
  logic [fekc_pkg::STAMP_W-1:0]    out_stamp_r;
  logic                            out_expired_r;
  logic [fekc_pkg::LIM_W-1:0]      out_count_r;
  logic                            out_evicted_r;
  logic [fekc_pkg::KEY_W-1:0]      out_evicted_id_r;

  logic                            ram_we;
  logic [SLOT_AW-1:0]              ram_waddr;
  logic [SLOT_AW-1:0]              ram_raddr;
  fekc_pkg::slot_t                 ram_wdata;
  logic [fekc_pkg::SLOT_W-1:0]     ram_rdata;

  fekc_pkg::slot_t                 rd_word;
  fekc_pkg::slot_t                 upd_word;
  fekc_pkg::slot_t                 new_word;
  logic                            in_fire;
  logic                            type_ok_c;
  logic                            key_match_c;
  logic                            older_c;
  logic                            scan_issue;
  logic                            scan_done;
  logic [CMP_W-1:0]                cnt_ext;
  logic [CMP_W-1:0]                lim_ext;
  logic [CMP_W-1:0]                eff_lim;
  logic                            evict_c;
  logic                            ins_go;
  logic [IDX_W-1:0]                ins_idx;
  logic                            fin_fire;
  logic                            fnd_ok;

  fekc_ram #(
    .WIDTH (fekc_pkg::SLOT_W),
    .DEPTH (SLOTS)
  ) u_slots (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign in_ready  = (state_r == fekc_pkg::ST_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign type_ok_c = 32'(in_cache_type) < NUM_TYPES;
  assign fin_fire  = (state_r == fekc_pkg::ST_FIN) && (!out_valid_r || out_ready);
  assign fnd_ok    = type_ok_r && fnd_r;

  // compare unit, one slot per cycle
  assign rd_word     = fekc_pkg::slot_t'(ram_rdata);
  assign key_match_c = rd_word.valid && (rd_word.key == key_r);
  assign older_c     = rd_word.valid &&
                       (!old_r || (rd_word.serial < old_ser_r) ||
                        ((rd_word.serial == old_ser_r) && (rd_word.key < old_key_r)));
  assign scan_issue  = rd_cnt_r != DEPTH_CNT;
  assign scan_done   = !scan_issue && !pend_r;
  assign ram_raddr   = base_r + SLOT_AW'(rd_cnt_r);

  assign cnt_ext = CMP_W'(type_count_r[type_r]);
  assign lim_ext = CMP_W'(type_limit_r[type_r]);
  assign eff_lim = ((lim_ext == '0) || (lim_ext > DEPTH_CMP)) ? DEPTH_CMP : lim_ext;
  assign evict_c = (mode_r == fekc_pkg::MODE_INSERT) && !fnd_r && old_r &&
                   (cnt_ext >= eff_lim);
  assign ins_go  = evict_r || free_r;
  assign ins_idx = (evict_r && !(free_r && (free_idx_r < old_idx_r))) ? old_idx_r
                                                                        : free_idx_r;

  always_comb begin
    upd_word         = fnd_word_r;
    upd_word.payload = pay_r;
    upd_word.version = ver_r;
    upd_word.stamp   = stamp_r;
    new_word         = '{valid: 1'b1, key: key_r, serial: next_serial_r[type_r],
                         version: ver_r, payload: pay_r, stamp: stamp_r};
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      fekc_pkg::ST_INIT: begin
        if (sweep_r == LAST_SLOT) state_nxt = fekc_pkg::ST_IDLE;
      end
      fekc_pkg::ST_IDLE: begin
        if (in_valid) state_nxt = type_ok_c ? fekc_pkg::ST_SCAN : fekc_pkg::ST_FIN;
      end
      fekc_pkg::ST_SCAN: begin
        if (scan_done) state_nxt = fekc_pkg::ST_DECIDE;
      end
      fekc_pkg::ST_DECIDE: begin
        if (mode_r == fekc_pkg::MODE_INSERT && !fnd_r) begin
          state_nxt = fekc_pkg::ST_INSERT;
        end else if (mode_r == fekc_pkg::MODE_CLEAR) begin
          state_nxt = fekc_pkg::ST_CLEAR;
        end else begin
          state_nxt = fekc_pkg::ST_FIN;
        end
      end
      fekc_pkg::ST_INSERT: state_nxt = fekc_pkg::ST_FIN;
      fekc_pkg::ST_CLEAR: begin
        if (sweep_r == LAST_IDX) state_nxt = fekc_pkg::ST_FIN;
      end
      fekc_pkg::ST_FIN: begin
        if (!out_valid_r || out_ready) state_nxt = fekc_pkg::ST_IDLE;
      end
      default: state_nxt = fekc_pkg::ST_INIT;
    endcase
  end

  // RAM write port
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = '0;
    ram_wdata = '0;
    unique case (state_r)
      fekc_pkg::ST_INIT: begin
        ram_we    = 1'b1;
        ram_waddr = SLOT_AW'(sweep_r);
      end
      fekc_pkg::ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = base_r + SLOT_AW'(sweep_r);
      end
      fekc_pkg::ST_DECIDE: begin
        if (mode_r == fekc_pkg::MODE_INSERT && fnd_r) begin
          ram_we    = 1'b1;
          ram_waddr = base_r + SLOT_AW'(fnd_idx_r);
          ram_wdata = upd_word;
        end else if (evict_c) begin
          ram_we    = 1'b1;
          ram_waddr = base_r + SLOT_AW'(old_idx_r);
        end else if (mode_r == fekc_pkg::MODE_REMOVE && fnd_r) begin
          ram_we    = 1'b1;
          ram_waddr = base_r + SLOT_AW'(fnd_idx_r);
        end
      end
      fekc_pkg::ST_INSERT: begin
        ram_we    = ins_go;
        ram_waddr = base_r + SLOT_AW'(ins_idx);
        ram_wdata = new_word;
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= fekc_pkg::ST_INIT;
      sweep_r     <= '0;
      out_valid_r <= 1'b0;
      for (int t = 0; t < NUM_TYPES; t++) begin
        type_count_r[t]  <= '0;
        type_limit_r[t]  <= '0;
        next_serial_r[t] <= fekc_pkg::SER_W'(1);
      end
    end else begin
      state_r <= state_nxt;
      if (out_valid_r && out_ready) out_valid_r <= 1'b0;
      if (fin_fire) out_valid_r <= 1'b1;
      unique case (state_r)
        fekc_pkg::ST_INIT: begin
          sweep_r <= (sweep_r == LAST_SLOT) ? '0 : sweep_r + 1'b1;
        end
        fekc_pkg::ST_DECIDE: begin
          if (evict_c || (mode_r == fekc_pkg::MODE_REMOVE && fnd_r)) begin
            type_count_r[type_r] <= type_count_r[type_r] - 1'b1;
          end
          if (mode_r == fekc_pkg::MODE_SET_LIMIT) type_limit_r[type_r] <= lim_r;
        end
        fekc_pkg::ST_INSERT: begin
          if (ins_go) begin
            type_count_r[type_r] <= type_count_r[type_r] + 1'b1;
            if (next_serial_r[type_r] != fekc_pkg::SER_MAX) begin
              next_serial_r[type_r] <= next_serial_r[type_r] + 1'b1;
            end
          end
        end
        fekc_pkg::ST_CLEAR: begin
          if (sweep_r == LAST_IDX) begin
            sweep_r               <= '0;
            type_count_r[type_r]  <= '0;
            next_serial_r[type_r] <= fekc_pkg::SER_W'(1);
          end else begin
            sweep_r <= sweep_r + 1'b1;
          end
        end
        default: begin
          sweep_r <= sweep_r;
        end
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (in_fire) begin
      mode_r    <= fekc_pkg::mode_t'(in_mode);
      type_r    <= TYPE_W'(in_cache_type);
      type_ok_r <= type_ok_c;
      key_r     <= in_entry_id;
      pay_r     <= in_payload;
      ver_r     <= in_version;
      stamp_r   <= in_timestamp;
      lim_r     <= in_limit_value;
      base_r    <= SLOT_AW'(TYPE_W'(in_cache_type) * TABLE_DEPTH);
      rd_cnt_r  <= '0;
      pend_r    <= 1'b0;
      fnd_r     <= 1'b0;
      old_r     <= 1'b0;
      free_r    <= 1'b0;
      evict_r   <= 1'b0;
    end
    if (state_r == fekc_pkg::ST_SCAN) begin
      pend_r     <= scan_issue;
      pend_idx_r <= IDX_W'(rd_cnt_r);
      if (scan_issue) rd_cnt_r <= rd_cnt_r + 1'b1;
      if (pend_r) begin
        if (key_match_c && !fnd_r) begin
          fnd_r      <= 1'b1;
          fnd_idx_r  <= pend_idx_r;
          fnd_word_r <= rd_word;
        end
        if (older_c) begin
          old_r     <= 1'b1;
          old_idx_r <= pend_idx_r;
          old_ser_r <= rd_word.serial;
          old_key_r <= rd_word.key;
        end
        if (!rd_word.valid && !free_r) begin
          free_r     <= 1'b1;
          free_idx_r <= pend_idx_r;
        end
      end
    end
    if (state_r == fekc_pkg::ST_DECIDE) evict_r <= evict_c;
    if (fin_fire) begin
      out_hit_r        <= fnd_ok;
      out_pay_r        <= (fnd_ok && mode_r == fekc_pkg::MODE_LOOKUP) ?
                          fnd_word_r.payload : '0;
      out_stamp_r      <= (fnd_ok && mode_r == fekc_pkg::MODE_LOOKUP) ?
                          fnd_word_r.stamp : '0;
      out_ver_r        <= fnd_ok ? fnd_word_r.version : '0;
      out_expired_r    <= type_ok_r && (mode_r == fekc_pkg::MODE_EXPIRY) &&
                          (!fnd_r || (fnd_word_r.version < ver_r));
      out_count_r      <= type_ok_r ? fekc_pkg::LIM_W'(type_count_r[type_r]) : '0;
      out_evicted_r    <= type_ok_r && evict_r;
      out_evicted_id_r <= (type_ok_r && evict_r) ? old_key_r : '0;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_hit              = out_hit_r;
  assign out_stored_payload   = out_pay_r;
  assign out_stored_version   = out_ver_r;
  assign out_stored_timestamp = out_stamp_r;
  assign out_expired          = out_expired_r;
  assign out_entry_count      = out_count_r;
  assign out_evicted          = out_evicted_r;
  assign out_evicted_id       = out_evicted_id_r;

`include "assert_macros.svh"

  `FEKC_ASSERT_NXT(a_busy_after_accept, in_valid && in_ready, !in_ready)
  `FEKC_ASSERT_IMP(a_miss_zero, out_valid && !out_hit, out_stored_version == '0 && out_stored_payload == '0 && out_stored_timestamp == '0)
  `FEKC_ASSERT_IMP(a_evict_is_miss, out_valid && out_evicted, !out_hit)
  `FEKC_ASSERT_IMP(a_count_bound, state_r == fekc_pkg::ST_FIN && type_ok_r, type_count_r[type_r] <= DEPTH_CNT)

endmodule
